>>> rtl/bkvm_pkg.sv
// Shared types and constants for the bijective key/value map.
package bkvm_pkg;

    localparam int ENTRIES_DEF    = 64;
    localparam int KEY_BITS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;
    localparam int CMD_BITS       = 3;
    localparam int FIELD_BITS     = 32;
    localparam int COUNT_BITS     = 7;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_INSERT       = 3'd0,
        CMD_REMOVE_KEY   = 3'd1,
        CMD_REMOVE_VALUE = 3'd2,
        CMD_LOOKUP_KEY   = 3'd3,
        CMD_LOOKUP_VALUE = 3'd4
    } t_cmd;

    typedef struct packed {
        logic found;
        logic full;
    } t_status;

endpackage

>>> rtl/bkvm_entries.sv
// Pair store with parallel key and value match, command decode and update.
module bkvm_entries #(
    parameter int ENTRIES    = bkvm_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = bkvm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = bkvm_pkg::VALUE_BITS_DEF,
    parameter int CNT_W      = $clog2(ENTRIES + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic [bkvm_pkg::CMD_BITS-1:0] i_cmd,
    input  logic [KEY_BITS-1:0]           i_key,
    input  logic [VALUE_BITS-1:0]         i_value,
    output bkvm_pkg::t_status             o_status,
    output logic [KEY_BITS-1:0]           o_key,
    output logic [VALUE_BITS-1:0]         o_value,
    output logic [CNT_W-1:0]              o_count
);
    import bkvm_pkg::*;

    logic [KEY_BITS-1:0]   r_key [ENTRIES];
    logic [VALUE_BITS-1:0] r_val [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;
    logic [ENTRIES-1:0]    n_valid;
    logic [CNT_W-1:0]      r_count;
    logic [CNT_W-1:0]      n_count;

    logic [ENTRIES-1:0]    key_hit;
    logic [ENTRIES-1:0]    val_hit;
    logic [ENTRIES-1:0]    free;
    logic [ENTRIES-1:0]    free_one;
    logic                  any_k;
    logic                  any_v;
    logic                  any_free;
    logic                  same_pair;
    logic [ENTRIES-1:0]    wr_sel;
    logic [ENTRIES-1:0]    set_sel;
    logic [ENTRIES-1:0]    clr_sel;
    logic [ENTRIES-1:0]    rd_sel;
    logic                  inc;
    logic                  dec;
    logic                  found;
    logic                  full;
    logic [KEY_BITS-1:0]   rd_key;
    logic [VALUE_BITS-1:0] rd_val;
    t_cmd                  cmd;

    assign cmd = t_cmd'(i_cmd);

    always_comb begin
        for (int i = 0; i < ENTRIES; i++) begin
            key_hit[i] = r_valid[i] && (r_key[i] == i_key);
            val_hit[i] = r_valid[i] && (r_val[i] == i_value);
        end
    end

    assign free      = ~r_valid;
    assign free_one  = free & (~free + ENTRIES'(1));
    assign any_k     = |key_hit;
    assign any_v     = |val_hit;
    assign any_free  = |free;
    assign same_pair = |(key_hit & val_hit);

    always_comb begin
        wr_sel  = '0;
        set_sel = '0;
        clr_sel = '0;
        rd_sel  = '0;
        inc     = 1'b0;
        dec     = 1'b0;
        found   = 1'b0;
        full    = 1'b0;
        unique case (cmd)
            CMD_INSERT: begin
                priority if (same_pair) begin
                    wr_sel = '0;
                end else if (any_k) begin
                    wr_sel  = key_hit;
                    clr_sel = val_hit;
                    dec     = any_v;
                end else if (any_v) begin
                    wr_sel = val_hit;
                end else if (any_free) begin
                    wr_sel  = free_one;
                    set_sel = free_one;
                    inc     = 1'b1;
                end else begin
                    full = 1'b1;
                end
            end
            CMD_REMOVE_KEY: begin
                found   = any_k;
                rd_sel  = key_hit;
                clr_sel = key_hit;
                dec     = any_k;
            end
            CMD_REMOVE_VALUE: begin
                found   = any_v;
                rd_sel  = val_hit;
                clr_sel = val_hit;
                dec     = any_v;
            end
            CMD_LOOKUP_KEY: begin
                found  = any_k;
                rd_sel = key_hit;
            end
            CMD_LOOKUP_VALUE: begin
                found  = any_v;
                rd_sel = val_hit;
            end
            default: begin
                found = 1'b0;
            end
        endcase
    end

    always_comb begin
        rd_key = '0;
        rd_val = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (rd_sel[i]) begin
                rd_key = rd_key | r_key[i];
                rd_val = rd_val | r_val[i];
            end
        end
    end

    assign n_valid = (r_valid & ~clr_sel) | set_sel;
    assign n_count = r_count + CNT_W'(inc) - CNT_W'(dec);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_count <= '0;
        end else if (i_en) begin
            r_valid <= n_valid;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ENTRIES; i++) begin
            if (i_en && wr_sel[i]) begin
                r_key[i] <= i_key;
                r_val[i] <= i_value;
            end
        end
    end

    assign o_status.found = found;
    assign o_status.full  = full;
    assign o_key          = rd_key;
    assign o_value        = rd_val;
    assign o_count        = n_count;

endmodule

>>> rtl/bijective_key_value_map.sv
// Top level of the bijective key/value map: input register, pair store, result register.
// Takes one transaction per clock cycle while the output side is ready, and returns one
// result per transaction. All stored pairs are compared against the key and the value at
// once in the single stage between the input and result registers, which also updates the
// store, so each command sees every earlier command's effect.
// The store is empty after reset and needs no clearing time.
module bijective_key_value_map #(
    parameter int ENTRIES    = bkvm_pkg::ENTRIES_DEF,
    parameter int KEY_BITS   = bkvm_pkg::KEY_BITS_DEF,
    parameter int VALUE_BITS = bkvm_pkg::VALUE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [bkvm_pkg::CMD_BITS-1:0]   i_command,
    input  logic [bkvm_pkg::FIELD_BITS-1:0] i_key_in,
    input  logic [bkvm_pkg::FIELD_BITS-1:0] i_value_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_found,
    output logic [bkvm_pkg::FIELD_BITS-1:0] o_key_out,
    output logic [bkvm_pkg::FIELD_BITS-1:0] o_value_out,
    output logic [bkvm_pkg::COUNT_BITS-1:0] o_pair_count,
    output logic                            o_full_flag
);
    import bkvm_pkg::*;

    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int KEY_EXT = (KEY_BITS > FIELD_BITS) ? KEY_BITS : FIELD_BITS;
    localparam int VAL_EXT = (VALUE_BITS > FIELD_BITS) ? VALUE_BITS : FIELD_BITS;
    localparam int CNT_EXT = (CNT_W > COUNT_BITS) ? CNT_W : COUNT_BITS;

    logic                  r_in_vld;
    logic [CMD_BITS-1:0]   r_cmd;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_out_vld;
    logic                  r_found;
    logic                  r_full;
    logic [FIELD_BITS-1:0] r_key_out;
    logic [FIELD_BITS-1:0] r_val_out;
    logic [COUNT_BITS-1:0] r_count;

    logic                  adv;
    logic [KEY_EXT-1:0]    key_in_ext;
    logic [VAL_EXT-1:0]    val_in_ext;
    logic [KEY_EXT-1:0]    key_out_ext;
    logic [VAL_EXT-1:0]    val_out_ext;
    logic [CNT_EXT-1:0]    cnt_ext;
    t_status               status;
    logic [KEY_BITS-1:0]   match_key;
    logic [VALUE_BITS-1:0] match_val;
    logic [CNT_W-1:0]      count;

    assign adv        = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_in_vld || adv;

    assign key_in_ext = KEY_EXT'(i_key_in);
    assign val_in_ext = VAL_EXT'(i_value_in);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_cmd <= i_command;
            r_key <= key_in_ext[KEY_BITS-1:0];
            r_val <= val_in_ext[VALUE_BITS-1:0];
        end
    end

    bkvm_entries #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS),
        .CNT_W      (CNT_W)
    ) u_entries (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (adv),
        .i_cmd    (r_cmd),
        .i_key    (r_key),
        .i_value  (r_val),
        .o_status (status),
        .o_key    (match_key),
        .o_value  (match_val),
        .o_count  (count)
    );

    assign key_out_ext = KEY_EXT'(match_key);
    assign val_out_ext = VAL_EXT'(match_val);
    assign cnt_ext     = CNT_EXT'(count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_found   <= status.found;
            r_full    <= status.full;
            r_key_out <= key_out_ext[FIELD_BITS-1:0];
            r_val_out <= val_out_ext[FIELD_BITS-1:0];
            r_count   <= cnt_ext[COUNT_BITS-1:0];
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_found      = r_found;
    assign o_full_flag  = r_full;
    assign o_key_out    = r_key_out;
    assign o_value_out  = r_val_out;
    assign o_pair_count = r_count;

endmodule

>>> rtl/bkvm_checker.sv
// Port-level checker for the bijective key/value map, bound to the top level.
module bkvm_checker #(
    parameter int ENTRIES = bkvm_pkg::ENTRIES_DEF
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input logic                            o_found,
    input logic [bkvm_pkg::FIELD_BITS-1:0] o_key_out,
    input logic [bkvm_pkg::FIELD_BITS-1:0] o_value_out,
    input logic [bkvm_pkg::COUNT_BITS-1:0] o_pair_count,
    input logic                            o_full_flag
);
    import bkvm_pkg::*;

    a_full_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_flag |-> !o_found)
        else $error("full flag together with found");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> o_key_out == '0 && o_value_out == '0)
        else $error("pair fields not zero on a miss");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_flag |-> o_pair_count == COUNT_BITS'(ENTRIES))
        else $error("full flag while entries remain free");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_key_out)
            && $stable(o_value_out) && $stable(o_pair_count))
        else $error("stalled result changed");

endmodule

bind bijective_key_value_map bkvm_checker #(.ENTRIES(ENTRIES)) u_bkvm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_found      (o_found),
    .o_key_out    (o_key_out),
    .o_value_out  (o_value_out),
    .o_pair_count (o_pair_count),
    .o_full_flag  (o_full_flag)
);

>>> test/tb.sv
// Self-checking testbench for the bijective key/value map: directed, table-full and random traffic.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bkvm_pkg::*;

    localparam int POOL_SIZE     = 96;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_LIMIT   = 5000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [CMD_BITS-1:0] CMD_RESERVED_LO  = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_RESERVED_MID = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_RESERVED_HI  = 3'd7;

    typedef struct packed {
        logic                  found;
        logic [FIELD_BITS-1:0] key;
        logic [FIELD_BITS-1:0] value;
        logic [COUNT_BITS-1:0] count;
        logic                  full;
    } t_map_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic [CMD_BITS-1:0]   i_command = '0;
    logic [FIELD_BITS-1:0] i_key_in = '0;
    logic [FIELD_BITS-1:0] i_value_in = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic                  o_found;
    logic [FIELD_BITS-1:0] o_key_out;
    logic [FIELD_BITS-1:0] o_value_out;
    logic [COUNT_BITS-1:0] o_pair_count;
    logic                  o_full_flag;

    // predicted table contents
    logic [FIELD_BITS-1:0] key_mem [ENTRIES_DEF];
    logic [FIELD_BITS-1:0] val_mem [ENTRIES_DEF];
    logic                  slot_used [ENTRIES_DEF];
    int                    pair_total;

    t_map_result           expected_results [$];
    t_map_result           want;
    logic [FIELD_BITS-1:0] key_pool [POOL_SIZE];
    logic [FIELD_BITS-1:0] value_pool [POOL_SIZE];
    int                    burst_left;
    int                    errors;
    int                    hold_req;
    int                    hold_seen = 0;
    int                    hold_left = 0;
    logic [15:0]           rx_cycle = '0;

    bijective_key_value_map u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_command    (i_command),
        .i_key_in     (i_key_in),
        .i_value_in   (i_value_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_found      (o_found),
        .o_key_out    (o_key_out),
        .o_value_out  (o_value_out),
        .o_pair_count (o_pair_count),
        .o_full_flag  (o_full_flag)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_map_result apply_command(logic [CMD_BITS-1:0] cmd,
                                                  logic [FIELD_BITS-1:0] k,
                                                  logic [FIELD_BITS-1:0] v);
        t_map_result r;
        int key_hit;
        int val_hit;
        int hit;
        int slot;
        r = '0;
        key_hit = -1;
        val_hit = -1;
        slot = -1;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            if (slot_used[i] && key_mem[i] == k && key_hit < 0) key_hit = i;
            if (slot_used[i] && val_mem[i] == v && val_hit < 0) val_hit = i;
            if (!slot_used[i] && slot < 0) slot = i;
        end
        hit = (cmd == CMD_REMOVE_KEY || cmd == CMD_LOOKUP_KEY) ? key_hit : val_hit;
        case (cmd)
            CMD_INSERT: begin
                if (key_hit >= 0 && val_mem[key_hit] == v) begin
                    r.full = 1'b0;
                end else if (key_hit >= 0) begin
                    if (val_hit >= 0 && val_hit != key_hit) begin
                        slot_used[val_hit] = 1'b0;
                        pair_total--;
                    end
                    val_mem[key_hit] = v;
                end else if (val_hit >= 0) begin
                    key_mem[val_hit] = k;
                end else if (slot < 0) begin
                    r.full = 1'b1;
                end else begin
                    key_mem[slot] = k;
                    val_mem[slot] = v;
                    slot_used[slot] = 1'b1;
                    pair_total++;
                end
            end
            CMD_REMOVE_KEY, CMD_REMOVE_VALUE, CMD_LOOKUP_KEY, CMD_LOOKUP_VALUE: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.key = key_mem[hit];
                    r.value = val_mem[hit];
                    if (cmd == CMD_REMOVE_KEY || cmd == CMD_REMOVE_VALUE) begin
                        slot_used[hit] = 1'b0;
                        pair_total--;
                    end
                end
            end
            default: begin
                r.found = 1'b0;
            end
        endcase
        r.count = pair_total[COUNT_BITS-1:0];
        return r;
    endfunction

    task automatic send_command(input logic [CMD_BITS-1:0] cmd,
                                input logic [FIELD_BITS-1:0] k,
                                input logic [FIELD_BITS-1:0] v);
        int gap;
        i_in_valid <= 1'b1;
        i_command  <= cmd;
        i_key_in   <= k;
        i_value_in <= v;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        expected_results.push_back(apply_command(cmd, k, v));
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(0, 8);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic test_directed();
        send_command(CMD_LOOKUP_KEY, '0, '0);
        send_command(CMD_REMOVE_VALUE, '1, '1);
        send_command(CMD_INSERT, '0, '0);
        send_command(CMD_INSERT, '0, '0);
        send_command(CMD_LOOKUP_KEY, '0, '1);
        send_command(CMD_INSERT, '1, '1);
        send_command(CMD_LOOKUP_VALUE, '0, '1);
        send_command(CMD_INSERT, '0, '1);
        send_command(CMD_LOOKUP_KEY, '1, '0);
        send_command(CMD_INSERT, 32'd5, '1);
        send_command(CMD_LOOKUP_VALUE, '0, '1);
        send_command(CMD_RESERVED_LO, '1, '1);
        send_command(CMD_RESERVED_MID, 32'd5, '0);
        send_command(CMD_RESERVED_HI, '0, '1);
        send_command(CMD_REMOVE_KEY, 32'd5, '0);
        send_command(CMD_REMOVE_KEY, 32'd5, '0);
        send_command(CMD_INSERT, 32'hAAAA_AAAA, 32'h5555_5555);
        send_command(CMD_INSERT, 32'h5555_5555, 32'hAAAA_AAAA);
        send_command(CMD_LOOKUP_KEY, 32'h5555_5555, '0);
        send_command(CMD_LOOKUP_VALUE, '0, 32'h5555_5555);
        send_command(CMD_REMOVE_VALUE, '0, 32'hAAAA_AAAA);
        send_command(CMD_REMOVE_KEY, 32'hAAAA_AAAA, '0);
    endtask

    task automatic test_full_table();
        int base;
        base = $urandom_range(0, POOL_SIZE - 1);
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            send_command(CMD_INSERT, key_pool[i], value_pool[(base + i) % POOL_SIZE]);
        end
        send_command(CMD_INSERT, key_pool[ENTRIES_DEF],
                     value_pool[(base + ENTRIES_DEF) % POOL_SIZE]);
        send_command(CMD_INSERT, key_pool[3], value_pool[(base + ENTRIES_DEF + 1) % POOL_SIZE]);
        send_command(CMD_INSERT, key_pool[ENTRIES_DEF + 2], value_pool[(base + 5) % POOL_SIZE]);
        send_command(CMD_INSERT, key_pool[7], value_pool[(base + 9) % POOL_SIZE]);
        send_command(CMD_LOOKUP_KEY, key_pool[3], $urandom);
        send_command(CMD_LOOKUP_VALUE, $urandom, value_pool[(base + 9) % POOL_SIZE]);
        send_command(CMD_INSERT, key_pool[ENTRIES_DEF + 3],
                     value_pool[(base + ENTRIES_DEF + 3) % POOL_SIZE]);
        send_command(CMD_INSERT, key_pool[ENTRIES_DEF + 4],
                     value_pool[(base + ENTRIES_DEF + 4) % POOL_SIZE]);
    endtask

    task automatic random_command();
        logic [CMD_BITS-1:0]   cmd;
        logic [FIELD_BITS-1:0] k;
        logic [FIELD_BITS-1:0] v;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)      cmd = CMD_INSERT;
        else if (pick < 55) cmd = CMD_LOOKUP_KEY;
        else if (pick < 70) cmd = CMD_LOOKUP_VALUE;
        else if (pick < 83) cmd = CMD_REMOVE_KEY;
        else if (pick < 96) cmd = CMD_REMOVE_VALUE;
        else                cmd = CMD_BITS'($urandom_range(CMD_RESERVED_LO, CMD_RESERVED_HI));
        k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
        v = ($urandom_range(0, 9) == 0) ? $urandom : value_pool[$urandom_range(0, POOL_SIZE - 1)];
        send_command(cmd, k, v);
    endtask

    task automatic test_backpressure();
        hold_req <= hold_req + 1;
        burst_left = 40;
        repeat (30) random_command();
    endtask

    task automatic test_random_mix();
        repeat (830) random_command();
    endtask

    task automatic finish_run();
        int waited;
        i_in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            errors++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    endtask

    // receiver: long hold on request, otherwise a rotating ready pattern
    always @(posedge i_clk) begin
        rx_cycle <= rx_cycle + 16'd1;
        if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left   <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else begin
            case (rx_cycle[9:8])
                2'd0:    i_out_ready <= 1'b1;
                2'd1:    i_out_ready <= ($urandom_range(0, 1) == 1);
                2'd2:    i_out_ready <= (rx_cycle[1:0] == 2'd3);
                default: i_out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: found=%0d key=%h value=%h count=%0d full=%0d",
                       o_found, o_key_out, o_value_out, o_pair_count, o_full_flag);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_found !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, o_found);
                    errors++;
                end
                if (o_key_out !== want.key) begin
                    $error("key_out: expected %h, got %h", want.key, o_key_out);
                    errors++;
                end
                if (o_value_out !== want.value) begin
                    $error("value_out: expected %h, got %h", want.value, o_value_out);
                    errors++;
                end
                if (o_pair_count !== want.count) begin
                    $error("pair_count: expected %0d, got %0d", want.count, o_pair_count);
                    errors++;
                end
                if (o_full_flag !== want.full) begin
                    $error("full_flag: expected %0d, got %0d", want.full, o_full_flag);
                    errors++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        errors = 0;
        burst_left = 0;
        pair_total = 0;
        hold_req = 0;
        for (int i = 0; i < ENTRIES_DEF; i++) begin
            key_mem[i] = '0;
            val_mem[i] = '0;
            slot_used[i] = 1'b0;
        end
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom;
            value_pool[i] = $urandom;
        end
        key_pool[0] = '0;
        key_pool[1] = '1;
        value_pool[0] = '0;
        value_pool[1] = '1;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_full_table();
        test_backpressure();
        test_random_mix();
        finish_run();
    end
endmodule
